FILE: design/small_set_table_top_assert.svh
// ----------------------------------------------------------------------------
// small_set_table_top_assert.svh
// Assertion macros shared by the set table RTL.
// ----------------------------------------------------------------------------
`ifndef SMALL_SET_TABLE_TOP_ASSERT_SVH
`define SMALL_SET_TABLE_TOP_ASSERT_SVH

// same-cycle implication, reset masked
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Types and operation codes of the small set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic               success;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

FILE: design/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/small_set_table_top.sv
// ----------------------------------------------------------------------------
// small_set_table_top
// Bounded set of distinct 32-bit values kept in insertion order.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// word follows, shown for one cycle under o_valid, and cannot be stalled.
// Clear answers in the cycle after it is taken and never raises busy. Add and
// query scan the stored entries through the single read port of the entry
// RAM, one entry per cycle, and stop at the first hit or after the last
// stored entry. Delete scans the same way; after a hit it moves each later
// entry down one place, one per cycle. busy stays high from an accepted scan
// until the cycle before its result, so the next command can be taken in the
// result cycle.
// ----------------------------------------------------------------------------
`include "small_set_table_top_assert.svh"

module small_set_table_top #(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  sst_pkg::t_cmd    i_cmd,
    output logic             busy,
    output logic             o_valid,
    output sst_pkg::t_result o_result
);

    import sst_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_op, n_op;
    logic [VALUE_W-1:0] r_val, n_val;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic               r_pend, n_pend;
    logic               r_valid, n_valid;
    t_result            r_result, n_result;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [VALUE_W-1:0] rd_data;
    logic               accept;
    logic               hit;

    sst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign accept = start && (r_state == ST_IDLE);
    assign hit    = r_pend && (rd_data == r_val);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_val    = r_val;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pend   = 1'b0;
        n_valid  = 1'b0;
        n_result = r_result;
        wr_en    = 1'b0;
        wr_addr  = r_pidx;
        wr_data  = rd_data;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op  = i_cmd.operation;
                    n_val = i_cmd.value;
                    n_idx = '0;
                    if (i_cmd.operation == OP_CLEAR) begin
                        n_count          = '0;
                        n_valid          = 1'b1;
                        n_result.success = 1'b1;
                        n_result.count   = '0;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    if (r_op == OP_DELETE) begin
                        // close the gap starting just past the match
                        n_idx   = CW'(r_pidx) + CW'(1);
                        n_state = ST_SHIFT;
                    end else begin
                        n_valid          = 1'b1;
                        n_result.success = (r_op == OP_QUERY);
                        n_result.count   = COUNT_W'(r_count);
                        n_state          = ST_IDLE;
                    end
                end else if (r_idx == r_count) begin
                    // miss: append on add if room remains
                    n_valid          = 1'b1;
                    n_result.success = 1'b0;
                    if ((r_op == OP_ADD) && (r_count < CW'(CAPACITY))) begin
                        wr_en            = 1'b1;
                        wr_addr          = r_count[AW-1:0];
                        wr_data          = r_val;
                        n_count          = r_count + CW'(1);
                        n_result.success = 1'b1;
                    end
                    n_result.count = COUNT_W'(n_count);
                    n_state        = ST_IDLE;
                end else begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CW'(1);
                end
            end
            ST_SHIFT: begin
                wr_en = r_pend;
                if (r_idx < r_count) begin
                    n_pend = 1'b1;
                    n_pidx = AW'(r_idx - CW'(1));
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_count          = r_count - CW'(1);
                    n_valid          = 1'b1;
                    n_result.success = 1'b1;
                    n_result.count   = COUNT_W'(n_count);
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `SST_ASSERT_NXT(a_progress, i_clk, i_rst_n, accept, busy || o_valid, "command stalled")
    `SST_ASSERT_IMP(a_shift_op, i_clk, i_rst_n,
        r_state == ST_SHIFT, r_op == OP_DELETE, "shift outside delete")
    `SST_ASSERT_IMP(a_count_max, i_clk, i_rst_n,
        1'b1, r_count <= CW'(CAPACITY), "count over capacity")
    `SST_ASSERT_IMP(a_wr_busy, i_clk, i_rst_n, wr_en, r_state != ST_IDLE, "entry write while idle")
    `SST_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n,
        r_state == ST_SCAN, r_idx <= r_count, "scan past count")

endmodule
